// File: src/rme_pkg.sv
// Shared types, constants and helper functions for the rotation-matrix-to-Euler block.
`timescale 1ns / 1ps
package rme_pkg;

	// datapath: Q2.14 input scaled by 2^16, with headroom for CORDIC gain
	localparam int DW = 36;
	// angle accumulator: degrees in signed Q.16
	localparam int ZW = 26;
	localparam int TABLE_LEN = 24;
	localparam int ELEM_W = 16;
	localparam int ANGLE_W = 16;
	localparam int PROD_W = 51;

	localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
	localparam logic signed [ZW-1:0] HALF_TURN_Q16 = 26'sd11796480;
	localparam logic signed [16:0] ANGLE_LIMIT = 17'sd23040;
	localparam logic [15:0] THRESH_RESET = 16'd1;

	// round(atan(2^-i) in degrees * 2^16)
	localparam logic [21:0] ATAN_DEG_Q16 [TABLE_LEN] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
		22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
		22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
		22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
	};

	// state handed from cell to cell
	typedef struct packed {
		logic zero;
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_t;

	// Q2.14 element to datapath scale
	function automatic logic signed [DW-1:0] to_work(input logic [ELEM_W-1:0] v);
		to_work = {{(DW-ELEM_W-16){v[ELEM_W-1]}}, v, 16'b0};
	endfunction

	// Q.16 degrees to Q.7 with round-half-up and saturation
	function automatic logic [ANGLE_W-1:0] to_q7(input logic signed [ZW-1:0] z);
		logic signed [ZW-1:0] zr;
		logic signed [16:0] r;
		zr = z + 26'sd256;
		r = 17'(zr >>> 9);
		if (r > ANGLE_LIMIT) begin
			r = ANGLE_LIMIT;
		end else if (r < -ANGLE_LIMIT) begin
			r = -ANGLE_LIMIT;
		end
		to_q7 = r[ANGLE_W-1:0];
	endfunction

endpackage

// File: src/rme_prerot.sv
// Entry cell of a CORDIC chain: zero detect and half-turn pre-rotation.
`timescale 1ns / 1ps
module rme_prerot import rme_pkg::*; #(
	parameter int SW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [DW-1:0] x,
	input  logic signed [DW-1:0] y,
	input  logic [SW-1:0]        side,
	output logic                 out_valid,
	output cordic_t              out_st,
	output logic [SW-1:0]        out_side
);

	logic    valid_q;
	cordic_t st_q;
	logic [SW-1:0] side_q;
	cordic_t st_d;

	// left half-plane vectors are turned by 180 degrees
	always_comb begin
		st_d.zero = (x == '0) && (y == '0);
		if (x < 0) begin
			st_d.x = -x;
			st_d.y = -y;
			st_d.z = (y >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
		end else begin
			st_d.x = x;
			st_d.y = y;
			st_d.z = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q   <= st_d;
			side_q <= side;
		end
	end

	assign out_valid = valid_q;
	assign out_st    = st_q;
	assign out_side  = side_q;

endmodule

// File: src/rme_cordic_cell.sv
// One CORDIC vectoring iteration with its pipeline register.
`timescale 1ns / 1ps
module rme_cordic_cell import rme_pkg::*; #(
	parameter int STAGE = 0,
	parameter int SW    = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  cordic_t       in_st,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output cordic_t       out_st,
	output logic [SW-1:0] out_side
);

	localparam logic signed [ZW-1:0] ATAN_I = ZW'(ATAN_DEG_Q16[STAGE]);

	logic    valid_q;
	cordic_t st_q;
	logic [SW-1:0] side_q;
	cordic_t st_d;
	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;

	// rotate toward the x axis; arithmetic shift is a floor shift
	always_comb begin
		dx = in_st.y >>> STAGE;
		dy = in_st.x >>> STAGE;
		st_d.zero = in_st.zero;
		if (in_st.y >= 0) begin
			st_d.x = in_st.x + dx;
			st_d.y = in_st.y - dy;
			st_d.z = in_st.z + ATAN_I;
		end else begin
			st_d.x = in_st.x - dx;
			st_d.y = in_st.y + dy;
			st_d.z = in_st.z - ATAN_I;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q   <= st_d;
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_st    = st_q;
	assign out_side  = side_q;

endmodule

// File: src/rme_cordic_chain.sv
// Row of CORDIC cells: pre-rotation cell followed by STAGES iteration cells.
`timescale 1ns / 1ps
module rme_cordic_chain import rme_pkg::*; #(
	parameter int STAGES = 16,
	parameter int SW     = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [DW-1:0] x,
	input  logic signed [DW-1:0] y,
	input  logic [SW-1:0]        side,
	output logic                 out_valid,
	output logic                 out_zero,
	output logic signed [DW-1:0] out_x,
	output logic signed [ZW-1:0] out_z,
	output logic [SW-1:0]        out_side
);

	logic          valid [STAGES+1];
	cordic_t       st    [STAGES+1];
	logic [SW-1:0] sd    [STAGES+1];

	rme_prerot #(.SW(SW)) u_pre (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(in_valid), .x(x), .y(y), .side(side),
		.out_valid(valid[0]), .out_st(st[0]), .out_side(sd[0])
	);

	for (genvar i = 0; i < STAGES; i++) begin : g_cell
		rme_cordic_cell #(.STAGE(i), .SW(SW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(valid[i]), .in_st(st[i]), .in_side(sd[i]),
			.out_valid(valid[i+1]), .out_st(st[i+1]), .out_side(sd[i+1])
		);
	end

	// zero vector gives zero angle; its x stays zero through the chain
	assign out_valid = valid[STAGES];
	assign out_zero  = st[STAGES].zero;
	assign out_x     = st[STAGES].x;
	assign out_z     = st[STAGES].zero ? '0 : st[STAGES].z;
	assign out_side  = sd[STAGES];

endmodule

// File: src/rotation_matrix_to_euler.sv
// Top level: rotation matrix to ZYX Euler angles through three rows of CORDIC cells, the last two side by side.
//
//  channel | dir | handshake        | content
//  s_      | in  | tvalid/tready    | tdata: r00 r10 r20 r21 r22 r12 r11 (16b each)
//  m_      | out | tvalid/tready    | tdata: roll pitch yaw (16b each), tuser: singular
//  cfg_    | in  | cfg_we           | cfg_wdata: singular threshold, Q2.14
//
// One transaction per cycle sustained while m_tready stays high; the pipe is the
// hypot/yaw cell row, one multiply stage, the pitch/roll cell rows and the output register.
// The whole pipe advances together; it holds when the output register is full and
// m_tready is low, and s_tready follows that. Reset empties the pipe, threshold = 1.
`timescale 1ns / 1ps
module rotation_matrix_to_euler import rme_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [111:0] s_tdata,   // r00, r10, r20, r21, r22, r12, r11 from bit 0 up
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [47:0]  m_tdata,   // roll_deg, pitch_deg, yaw_deg from bit 0 up
	output logic         m_tuser,   // singular
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata
);

	localparam int SA_W = 5 * ELEM_W;

	logic        en;
	logic [15:0] thresh_q;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_we) begin
			thresh_q <= cfg_wdata;
		end
	end

	// global advance
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// first row: hypot and yaw of (r00, r10), other elements ride along
	logic                 a_valid;
	logic                 a_zero;
	logic signed [DW-1:0] a_x;
	logic signed [ZW-1:0] a_z;
	logic [SA_W-1:0]      a_side;

	rme_cordic_chain #(.STAGES(CORDIC_STAGES), .SW(SA_W)) u_chain_a (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(s_tvalid),
		.x(to_work(s_tdata[15:0])), .y(to_work(s_tdata[31:16])),
		.side(s_tdata[111:32]),
		.out_valid(a_valid), .out_zero(a_zero), .out_x(a_x), .out_z(a_z),
		.out_side(a_side)
	);

	// magnitude scaling by inverse gain, yaw to Q.7
	logic                 valid_s1;
	logic [PROD_W-1:0]    prod_s1;
	logic [ANGLE_W-1:0]   yaw_s1;
	logic [SA_W-1:0]      side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= a_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(a_x[DW-2:0]) * PROD_W'(INV_GAIN_Q16);
			yaw_s1  <= to_q7(a_z);
			side_s1 <= a_side;
		end
	end

	// singular decision and second-row operands
	logic [PROD_W-1:0]    work_rnd;
	logic [PROD_W-1:0]    q14_rnd;
	logic signed [DW-1:0] sy_work;
	logic [18:0]          sy_q14;
	logic                 sing;
	logic signed [DW-1:0] roll_x;
	logic signed [DW-1:0] roll_y;
	logic signed [DW-1:0] pitch_y;

	always_comb begin
		work_rnd = prod_s1 + PROD_W'(32768);
		q14_rnd  = prod_s1 + (PROD_W'(1) << 31);
		sy_work  = DW'(work_rnd[PROD_W-1:16]);
		sy_q14   = q14_rnd[PROD_W-1:32];
		sing     = sy_q14 < {3'b0, thresh_q};
		pitch_y  = -to_work(side_s1[15:0]);
		if (sing) begin
			roll_x = to_work(side_s1[79:64]);
			roll_y = -to_work(side_s1[63:48]);
		end else begin
			roll_x = to_work(side_s1[47:32]);
			roll_y = to_work(side_s1[31:16]);
		end
	end

	// second rows: pitch and roll side by side
	logic                 p_valid;
	logic                 p_zero;
	logic signed [DW-1:0] p_x;
	logic signed [ZW-1:0] p_z;
	logic                 p_sing;
	logic                 r_valid;
	logic                 r_zero;
	logic signed [DW-1:0] r_x;
	logic signed [ZW-1:0] r_z;
	logic [ANGLE_W-1:0]   r_yaw;

	rme_cordic_chain #(.STAGES(CORDIC_STAGES), .SW(1)) u_chain_p (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s1), .x(sy_work), .y(pitch_y), .side(sing),
		.out_valid(p_valid), .out_zero(p_zero), .out_x(p_x), .out_z(p_z),
		.out_side(p_sing)
	);

	rme_cordic_chain #(.STAGES(CORDIC_STAGES), .SW(ANGLE_W)) u_chain_r (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s1), .x(roll_x), .y(roll_y),
		.side(sing ? '0 : yaw_s1),
		.out_valid(r_valid), .out_zero(r_zero), .out_x(r_x), .out_z(r_z),
		.out_side(r_yaw)
	);

	// output register
	logic               out_valid_q;
	logic [47:0]        out_data_q;
	logic               out_sing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= p_valid && r_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {r_yaw, to_q7(p_z), to_q7(r_z)};
			out_sing_q <= p_sing;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_sing_q;

`ifndef ASSERT_OFF
	// singular results carry zero yaw
	a_sing_yaw: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[47:32] == '0)
		else $error("yaw not zero on singular result");

	// roll stays inside +-180 degrees
	a_roll_rng: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[15:0]) <= 16'sd23040
			&& $signed(m_tdata[15:0]) >= -16'sd23040)
		else $error("roll out of range");

	// pitch and roll rows move in lockstep
	a_rows_sync: assert property (@(posedge clk) disable iff (!arst_n)
		p_valid == r_valid)
		else $error("pitch and roll rows out of step");

	// zero vector keeps a zero magnitude through each row
	a_zero_mag: assert property (@(posedge clk) disable iff (!arst_n)
		(!(a_valid && a_zero) || a_x == '0)
		&& (!(p_valid && p_zero) || p_x == '0)
		&& (!(r_valid && r_zero) || r_x == '0))
		else $error("zero vector gave nonzero magnitude");
`endif

endmodule
